@@ hdl/sil_pkg.sv @@
`default_nettype none

package sil_pkg;

	// Result codes carried on event_res.
	typedef enum logic [1:0] {
		EV_WRITE  = 2'd0,
		EV_ACCEPT = 2'd1,
		EV_REJECT = 2'd2
	} ev_t;

	// Register indexes, taken from paddr[2].
	localparam logic REG_LOAD_BASE = 1'b0;
	localparam logic REG_MAGIC     = 1'b1;

	localparam logic [31:0] RESET_LOAD_BASE = 32'h8200_0000;
	localparam logic [31:0] RESET_MAGIC     = 32'h544F_4F42;

	localparam int unsigned HDR_LAST = 7;

	// Configuration handed from the register block to the engine.
	typedef struct packed {
		logic [31:0] load_base;
		logic [31:0] expected_magic;
	} cfg_t;

endpackage

`default_nettype wire

@@ hdl/sil_apb_regs.sv @@
`default_nettype none

module sil_apb_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output sil_pkg::cfg_t    cfg
);
	import sil_pkg::*;

	logic [31:0] load_base_q;
	logic [31:0] magic_q;
	logic        wr_en;

	// The low address bits are not decoded; the register is selected by paddr[2].
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_base_q <= RESET_LOAD_BASE;
			magic_q     <= RESET_MAGIC;
		end else if (wr_en) begin
			case (paddr[2])
				REG_LOAD_BASE: load_base_q <= pwdata;
				REG_MAGIC:     magic_q     <= pwdata;
				default:       load_base_q <= load_base_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_MAGIC) ? magic_q : load_base_q;

	assign cfg.load_base      = load_base_q;
	assign cfg.expected_magic = magic_q;

endmodule

`default_nettype wire

@@ hdl/sil_engine.sv @@
`default_nettype none

module sil_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_valid_s1,
	input  wire logic [7:0]    byte_s1,
	input  wire sil_pkg::cfg_t cfg,
	output logic               take,
	output logic               res_valid,
	input  wire logic          res_stall,
	output logic      [1:0]    event_res,
	output logic      [32:0]   write_address,
	output logic      [7:0]    write_data,
	output logic      [31:0]   image_size,
	output logic               transfer_done
);
	import sil_pkg::*;

	logic        phase_q;
	logic [2:0]  cnt_q;
	logic [55:0] hdr_q;
	logic [31:0] rem_q;
	logic [31:0] off_q;

	logic        res_valid_q;
	ev_t         ev_q;
	logic [32:0] addr_q;
	logic [7:0]  data_q;
	logic [31:0] size_q;
	logic        done_q;

	logic        out_free;
	logic        hdr_last;
	logic [31:0] magic_w;
	logic [31:0] size_w;
	logic        magic_ok;
	logic        pay_last;
	logic        produce;

	assign out_free = !res_valid_q || !res_stall;
	assign take     = byte_valid_s1 && out_free;

	assign hdr_last = (cnt_q == 3'(HDR_LAST));
	assign magic_w  = hdr_q[31:0];
	assign size_w   = {byte_s1, hdr_q[55:32]};
	assign magic_ok = (magic_w == cfg.expected_magic);
	assign pay_last = (rem_q <= 32'd1);
	assign produce  = phase_q || hdr_last;

	// Header and payload state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			cnt_q   <= '0;
			rem_q   <= '0;
			off_q   <= '0;
		end else if (take) begin
			if (!phase_q) begin
				if (!hdr_last) begin
					cnt_q <= cnt_q + 3'd1;
				end else begin
					cnt_q <= '0;
					if (magic_ok && (size_w != 32'd0)) begin
						phase_q <= 1'b1;
						rem_q   <= size_w;
						off_q   <= '0;
					end
				end
			end else if (pay_last) begin
				phase_q <= 1'b0;
				rem_q   <= '0;
				off_q   <= '0;
			end else begin
				rem_q <= rem_q - 32'd1;
				off_q <= off_q + 32'd1;
			end
		end
	end

	// Every lane is written before the eighth byte reads it, so no clear is needed.
	always_ff @(posedge clk) begin
		if (take && !phase_q && !hdr_last) begin
			hdr_q[8*cnt_q +: 8] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && produce) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && produce) begin
			if (phase_q) begin
				ev_q   <= EV_WRITE;
				addr_q <= {1'b0, cfg.load_base} + {1'b0, off_q};
				data_q <= byte_s1;
				size_q <= '0;
				done_q <= pay_last;
			end else begin
				ev_q   <= magic_ok ? EV_ACCEPT : EV_REJECT;
				addr_q <= '0;
				data_q <= '0;
				size_q <= size_w;
				done_q <= magic_ok && (size_w == 32'd0);
			end
		end
	end

	assign res_valid     = res_valid_q;
	assign event_res     = ev_q;
	assign write_address = addr_q;
	assign write_data    = data_q;
	assign image_size    = size_q;
	assign transfer_done = done_q;

	a_payload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (rem_q != 32'd0))
		else $error("payload phase with nothing left to receive");

	a_offset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!phase_q |-> (off_q == 32'd0))
		else $error("payload offset not cleared outside payload phase");

	a_phase_from_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q) |-> ($past(take) && $past(hdr_last)))
		else $error("payload phase entered without an eighth header byte");

	a_reject_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (ev_q == EV_REJECT)) |-> !done_q)
		else $error("rejected header flagged as complete");

endmodule

`default_nettype wire

@@ hdl/serial_image_loader_core.sv @@
`default_nettype none

// Serial image loader. Received bytes enter on the rx channel (rx_valid,
// rx_stall, rx_byte), one request per byte. The first eight bytes form a
// little-endian header: magic word, then image size. The eighth byte yields an
// accept or reject request on the result channel (res_valid, res_stall and the
// result fields); after an accept, each of the next image_size bytes yields one
// memory write request at load_base plus its offset, and the last one carries
// transfer_done. A zero size flags transfer_done on the accept itself.
// Registers load_base (address 0) and expected_magic (address 4) sit on the
// APB port; pready is always high.
// Timing: a byte is registered in the input stage at acceptance; its result is
// registered when the engine takes the byte from that stage. One byte is taken
// every cycle while the result side keeps up; the single result register sets
// that figure.
// Reset clears the header count, the payload phase and the registers to their
// defaults. When the receiver stalls, the result holds and the input stage
// holds its byte, so rx_stall rises while a byte is waiting.
module serial_image_loader_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic      [1:0]  event_res,
	output logic      [32:0] write_address,
	output logic      [7:0]  write_data,
	output logic      [31:0] image_size,
	output logic             transfer_done
);
	import sil_pkg::*;

	cfg_t       cfg;
	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       take;
	logic       rx_take;

	sil_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The input stage stalls only while it holds a byte the engine cannot take.
	assign rx_stall = byte_valid_s1 && !take;
	assign rx_take  = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx_take) begin
			byte_valid_s1 <= 1'b1;
		end else if (take) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx_byte;
		end
	end

	sil_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid_s1 (byte_valid_s1),
		.byte_s1       (byte_s1),
		.cfg           (cfg),
		.take          (take),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.event_res     (event_res),
		.write_address (write_address),
		.write_data    (write_data),
		.image_size    (image_size),
		.transfer_done (transfer_done)
	);

endmodule

`default_nettype wire

@@ tb/serial_image_loader_core_test.sv @@
`default_nettype none

// Testbench for the serial image loader.
//
// Bytes are pushed into the rx channel one request at a time. At every rx
// acceptance a behavioral copy of the loader in this file works out the result
// the byte should cause, if any, and queues it. Results taken from the result
// channel are compared, field by field, against the oldest queued entry.
//
// The run opens with a short table of bytes: one accepted image with a payload
// of two bytes, one rejected header with every bit of the size set, and one
// accepted image of size zero. After that come several phases, each with its
// own register setting. Most traffic is well-formed images carrying the
// configured magic and random payload. The rest is headers with a corrupted
// magic and wholly random headers. One phase holds the result side off for a
// long stretch while bytes keep arriving. The run ends with an image whose
// size is so large that it is still loading when the stimulus stops.
module serial_image_loader_core_test;

	import sil_pkg::*;

	// A watchdog ends the run after this many cycles without any traffic.
	localparam int QUIET_LIMIT = 2000;
	// The long hold-off on the result side.
	localparam int HOLD_CYCLES = 64;
	// Cycles to let pass once nothing is expected, so that a header byte that
	// causes no result has left the pipeline.
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_COUNT = 6;
	localparam int ITEMS_PER_PHASE = 64;

	typedef struct packed {
		ev_t         ev;
		logic [32:0] addr;
		logic [7:0]  data;
		logic [31:0] size;
		logic        done;
	} loader_result_t;

	// One row of the opening table. Rows with hand_checked set carry their
	// expected outcome typed in; the other rows rely on the loader copy.
	typedef struct packed {
		logic [7:0]     rx;
		logic           hand_checked;
		logic           has_res;
		loader_result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte = '0;
	logic        res_valid;
	logic        res_stall = 1'b1;
	logic [1:0]  event_res;
	logic [32:0] write_address;
	logic [7:0]  write_data;
	logic [31:0] image_size;
	logic        transfer_done;

	// Register copies and loader state kept by the testbench.
	logic [31:0] cfg_base = RESET_LOAD_BASE;
	logic [31:0] cfg_magic = RESET_MAGIC;
	logic        in_payload = 1'b0;
	logic [2:0]  hdr_count = '0;
	logic [63:0] hdr_bytes = '0;
	logic [31:0] bytes_left = '0;
	logic [31:0] next_offset = '0;

	loader_result_t pending_results[$];
	stim_row_t      stim_rows[$];
	loader_result_t head;

	int fail_count = 0;
	int quiet_cycles = 0;

	// tx_burst and rx_burst switch off the random gaps on either side.
	// hold_req asks the result side for the long hold-off.
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit hold_req = 1'b0;

	serial_image_loader_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.event_res     (event_res),
		.write_address (write_address),
		.write_data    (write_data),
		.image_size    (image_size),
		.transfer_done (transfer_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Loader behavior for one received byte. Returns 1 when the byte causes a
	// result, which is then in res. Header bytes are gathered little-endian;
	// the eighth one decides accept or reject against the magic register.
	function automatic bit advance_loader(input logic [7:0] b, output loader_result_t res);
		logic [31:0] magic;
		logic [31:0] size;
		res.ev = EV_WRITE;
		res.addr = '0;
		res.data = '0;
		res.size = '0;
		res.done = 1'b0;
		if (!in_payload) begin
			hdr_bytes[{hdr_count, 3'b000} +: 8] = b;
			if (hdr_count < HDR_LAST) begin
				hdr_count = hdr_count + 3'd1;
				return 1'b0;
			end
			magic = hdr_bytes[31:0];
			size = hdr_bytes[63:32];
			hdr_count = '0;
			hdr_bytes = '0;
			res.size = size;
			if (magic != cfg_magic) begin
				res.ev = EV_REJECT;
				return 1'b1;
			end
			// An empty image is complete as soon as its header is accepted.
			res.ev = EV_ACCEPT;
			res.done = (size == 32'd0);
			if (size != 32'd0) begin
				in_payload = 1'b1;
				bytes_left = size;
				next_offset = '0;
			end
			return 1'b1;
		end
		// The address is formed one bit wider than the base, so it never wraps.
		res.addr = {1'b0, cfg_base} + {1'b0, next_offset};
		res.data = b;
		res.done = (bytes_left <= 32'd1);
		if (bytes_left <= 32'd1) begin
			in_payload = 1'b0;
			bytes_left = '0;
			next_offset = '0;
		end else begin
			bytes_left = bytes_left - 32'd1;
			next_offset = next_offset + 32'd1;
		end
		return 1'b1;
	endfunction

	function automatic stim_row_t row_none(input logic [7:0] rx);
		stim_row_t r;
		r = '0;
		r.rx = rx;
		r.hand_checked = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t row_res(input logic [7:0] rx, input ev_t ev,
			input logic [32:0] addr, input logic [7:0] data, input logic [31:0] size,
			input logic done);
		stim_row_t r;
		r.rx = rx;
		r.hand_checked = 1'b1;
		r.has_res = 1'b1;
		r.res.ev = ev;
		r.res.addr = addr;
		r.res.data = data;
		r.res.size = size;
		r.res.done = done;
		return r;
	endfunction

	function automatic stim_row_t row_model(input logic [7:0] rx);
		stim_row_t r;
		r = '0;
		r.rx = rx;
		return r;
	endfunction

	function automatic logic [2:0] reg_addr(input logic idx);
		return {idx, 2'b00};
	endfunction

	// One APB transfer: setup cycle, access cycle, then an idle cycle so that
	// psel falls and rises on different edges. pready is always high, so the
	// access phase never waits and prdata is sampled at its end.
	task automatic apb_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic idx, input logic [31:0] want);
		logic [31:0] got;
		apb_access(1'b0, reg_addr(idx), '0, got);
		if (got !== want) begin
			$error("prdata at %0d: expected %h, got %h", reg_addr(idx), want, got);
			fail_count++;
		end
	endtask

	task automatic set_register(input logic idx, input logic [31:0] value);
		logic [31:0] unused;
		apb_access(1'b1, reg_addr(idx), value, unused);
		if (idx == REG_LOAD_BASE)
			cfg_base = value;
		else
			cfg_magic = value;
		check_register(idx, value);
	endtask

	// Offers one byte after a random gap and returns at the edge where the
	// request is taken. valid stays high across back-to-back requests.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall !== 1'b0)
			@(posedge clk);
	endtask

	task automatic feed_byte(input logic [7:0] b);
		loader_result_t res;
		send_byte(b);
		if (advance_loader(b, res))
			pending_results.push_back(res);
	endtask

	task automatic feed_header(input logic [31:0] magic, input logic [31:0] size);
		logic [63:0] hdr;
		hdr = {size, magic};
		for (int i = 0; i < 8; i++)
			feed_byte(hdr[8*i +: 8]);
	endtask

	// Mostly accepted images, small sizes with the odd larger one; the rest are
	// headers with one magic bit flipped and wholly random headers, which carry
	// random sizes and get rejected.
	task automatic run_traffic(input int n_items);
		int sent;
		int pick;
		logic [31:0] magic;
		logic [31:0] size;
		sent = 0;
		while (sent < n_items) begin
			tx_burst = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				magic = cfg_magic;
				size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
					: $urandom_range(0, 12);
			end else begin
				if (pick < 9)
					magic = cfg_magic ^ (32'd1 << $urandom_range(0, 31));
				else
					magic = $urandom;
				if (magic == cfg_magic)
					magic = ~magic;
				size = $urandom;
			end
			feed_header(magic, size);
			sent += 8;
			if (magic == cfg_magic) begin
				repeat (size) feed_byte(8'($urandom));
				sent += size;
			end
		end
		tx_burst = 1'b0;
	endtask

	// Drops valid and waits until every queued result has come back, then a
	// few more cycles for a header byte that causes no result.
	task automatic wait_idle();
		rx_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: a random stall before each result, runs without stalls now
	// and then, and the long hold-off when asked for.
	initial begin : result_sink
		int wait_cycles;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if ($urandom_range(0, 31) == 0)
				rx_burst = !rx_burst;
			wait_cycles = rx_burst ? 0 : $urandom_range(0, 8);
			if (wait_cycles != 0) begin
				res_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (res_valid !== 1'b1)
				@(posedge clk);
		end
	end

	// Every taken result is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result with none expected: event_res %0d", event_res);
				fail_count++;
			end else begin
				head = pending_results.pop_front();
				if (event_res !== head.ev) begin
					$error("event_res: expected %0d, got %0d", head.ev, event_res);
					fail_count++;
				end
				if (write_address !== head.addr) begin
					$error("write_address: expected %h, got %h", head.addr, write_address);
					fail_count++;
				end
				if (write_data !== head.data) begin
					$error("write_data: expected %h, got %h", head.data, write_data);
					fail_count++;
				end
				if (image_size !== head.size) begin
					$error("image_size: expected %h, got %h", head.size, image_size);
					fail_count++;
				end
				if (transfer_done !== head.done) begin
					$error("transfer_done: expected %b, got %b", head.done, transfer_done);
					fail_count++;
				end
			end
		end
	end

	// Any request on either channel or any register access counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall) || psel)
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : stimulus
		loader_result_t predicted;
		bit got;
		logic [31:0] base_val;
		logic [31:0] magic_val;

		// Accepted header with the reset magic and a size of two, then the two
		// payload bytes at the reset base; the second one finishes the image.
		stim_rows.push_back(row_none(8'h42));
		stim_rows.push_back(row_none(8'h4F));
		stim_rows.push_back(row_none(8'h4F));
		stim_rows.push_back(row_none(8'h54));
		stim_rows.push_back(row_none(8'h02));
		stim_rows.push_back(row_none(8'h00));
		stim_rows.push_back(row_none(8'h00));
		stim_rows.push_back(row_res(8'h00, EV_ACCEPT, '0, '0, 32'd2, 1'b0));
		stim_rows.push_back(row_res(8'h00, EV_WRITE, 33'h0_8200_0000, 8'h00, '0, 1'b0));
		stim_rows.push_back(row_res(8'hFF, EV_WRITE, 33'h0_8200_0001, 8'hFF, '0, 1'b1));
		// All-ones header: wrong magic, so rejected, and the size is all ones.
		repeat (7) stim_rows.push_back(row_none(8'hFF));
		stim_rows.push_back(row_res(8'hFF, EV_REJECT, '0, '0, 32'hFFFF_FFFF, 1'b0));
		// Image of size zero: done is flagged on the accept itself.
		stim_rows.push_back(row_model(8'h42));
		stim_rows.push_back(row_model(8'h4F));
		stim_rows.push_back(row_model(8'h4F));
		stim_rows.push_back(row_model(8'h54));
		stim_rows.push_back(row_model(8'h00));
		stim_rows.push_back(row_model(8'h00));
		stim_rows.push_back(row_model(8'h00));
		stim_rows.push_back(row_res(8'h00, EV_ACCEPT, '0, '0, 32'd0, 1'b1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_register(REG_LOAD_BASE, RESET_LOAD_BASE);
		check_register(REG_MAGIC, RESET_MAGIC);

		foreach (stim_rows[i]) begin
			send_byte(stim_rows[i].rx);
			got = advance_loader(stim_rows[i].rx, predicted);
			if (stim_rows[i].hand_checked) begin
				if (stim_rows[i].has_res)
					pending_results.push_back(stim_rows[i].res);
			end else if (got)
				pending_results.push_back(predicted);
		end
		wait_idle();

		// Phases: all zeros, all ones with a base that makes the address carry
		// past 32 bits, random settings, and finally the reset values again.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin
					base_val = '0;
					magic_val = '0;
				end
				1: begin
					base_val = 32'hFFFF_FFF8;
					magic_val = '1;
				end
				PHASE_COUNT - 1: begin
					base_val = RESET_LOAD_BASE;
					magic_val = RESET_MAGIC;
				end
				default: begin
					base_val = $urandom;
					magic_val = $urandom;
				end
			endcase
			if ($urandom_range(0, 1) == 0) begin
				set_register(REG_LOAD_BASE, base_val);
				set_register(REG_MAGIC, magic_val);
			end else begin
				set_register(REG_MAGIC, magic_val);
				set_register(REG_LOAD_BASE, base_val);
			end

			// The result side freezes right after the accept while payload
			// bytes keep coming, so the block fills up and stalls rx.
			if (p == 1) begin
				tx_burst = 1'b1;
				hold_req = 1'b1;
				feed_header(cfg_magic, 32'd40);
				repeat (40) feed_byte(8'($urandom));
				tx_burst = 1'b0;
			end

			run_traffic(ITEMS_PER_PHASE);
			wait_idle();
		end

		// An image far too large to finish: the run stops mid-payload.
		feed_header(cfg_magic, 32'hFFFF_FFFF);
		repeat (48) feed_byte(8'($urandom));
		wait_idle();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/sil_pkg.sv
hdl/sil_apb_regs.sv
hdl/sil_engine.sv
hdl/serial_image_loader_core.sv
tb/serial_image_loader_core_test.sv
